// ===== design/cpno_pkg.sv =====
// Shared types and constants for the control polygon normal offset block.
// Used by every module of the block; depends on nothing.

package cpno_pkg;

  localparam int COORD_W   = 32;  // point and offset coordinate width
  localparam int SCL_W     = 16;  // block-scaled component width (signed)
  localparam int WIDE_W    = 34;  // widest vector component fed to the scaler
  localparam int PROD_W    = 64;  // product magnitude width
  localparam int ROOT_W    = 31;  // square root result width
  localparam int RAD_W     = 62;  // square root radicand width
  localparam int DIV_Q_W   = 32;  // quotient width
  localparam int DIV_NUM_W = 61;  // dividend width
  localparam int UNIT_FRAC = 30;  // fraction bits of a unit vector

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      last_point;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] moved_x;
    logic signed [COORD_W-1:0] moved_y;
    logic signed [COORD_W-1:0] moved_z;
    logic                      degenerate;
    logic                      too_few_points;
    logic                      last_result;
  } result_t;

  // Status of the block scaler.
  typedef struct packed {
    logic busy;
    logic zero;
  } bs_stat_t;

endpackage

// ===== design/cpno_mul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle, shift and add.
// Depends on cpno_pkg.

module cpno_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [cpno_pkg::COORD_W-1:0] a,
  input  logic signed [cpno_pkg::COORD_W-1:0] b,
  output logic                                busy,
  output logic        [cpno_pkg::PROD_W-1:0]  prod_mag,
  output logic                                prod_neg
);

  logic [cpno_pkg::PROD_W-1:0]  ma;
  logic [cpno_pkg::COORD_W-1:0] mb;
  logic [cpno_pkg::COORD_W-1:0] a_mag;
  logic [cpno_pkg::COORD_W-1:0] b_mag;

  assign a_mag = a[cpno_pkg::COORD_W-1] ? cpno_pkg::COORD_W'(-a) : cpno_pkg::COORD_W'(a);
  assign b_mag = b[cpno_pkg::COORD_W-1] ? cpno_pkg::COORD_W'(-b) : cpno_pkg::COORD_W'(b);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy     <= 1'b1;
      ma       <= cpno_pkg::PROD_W'(a_mag);
      mb       <= b_mag;
      prod_mag <= '0;
      prod_neg <= a[cpno_pkg::COORD_W-1] ^ b[cpno_pkg::COORD_W-1];
    end else if (busy) begin
      // Finishes as soon as no multiplier bits remain.
      if (mb == '0) begin
        busy <= 1'b0;
      end else begin
        if (mb[0]) begin
          prod_mag <= prod_mag + ma;
        end
        ma <= ma << 1;
        mb <= mb >> 1;
      end
    end
  end

endmodule

// ===== design/cpno_sqrt.sv =====
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on cpno_pkg.

module cpno_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [cpno_pkg::RAD_W-1:0]        rad,
  output logic                              busy,
  output logic [cpno_pkg::ROOT_W-1:0]       root
);

  localparam int REM_W = cpno_pkg::ROOT_W + 4;
  localparam int CNT_W = $clog2(cpno_pkg::RAD_W / 2 + 1);

  logic [cpno_pkg::RAD_W-1:0] rad_sh;
  logic [REM_W-1:0]           rem;
  logic [CNT_W-1:0]           cnt;
  logic [REM_W-1:0]           r2;
  logic [REM_W-1:0]           trial;

  assign r2    = {rem[REM_W-3:0], rad_sh[cpno_pkg::RAD_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy   <= 1'b1;
      rad_sh <= rad;
      rem    <= '0;
      root   <= '0;
      cnt    <= CNT_W'(cpno_pkg::RAD_W / 2);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        if (r2 >= trial) begin
          rem  <= r2 - trial;
          root <= {root[cpno_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= r2;
          root <= {root[cpno_pkg::ROOT_W-2:0], 1'b0};
        end
        rad_sh <= rad_sh << 2;
        cnt    <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== design/cpno_div.sv =====
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in DIV_Q_W bits.
// Depends on cpno_pkg.

module cpno_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [cpno_pkg::DIV_NUM_W-1:0]       num,
  input  logic [cpno_pkg::ROOT_W-1:0]          den,
  output logic                                 busy,
  output logic [cpno_pkg::DIV_Q_W-1:0]         quo
);

  localparam int REM_W = cpno_pkg::ROOT_W + 1;
  localparam int CNT_W = $clog2(cpno_pkg::DIV_Q_W + 1);

  logic [REM_W-1:0]            rem;
  logic [cpno_pkg::DIV_Q_W-1:0] lo;
  logic [CNT_W-1:0]            cnt;
  logic [REM_W:0]              sh;
  logic [REM_W:0]              diff;

  assign sh   = {rem, lo[cpno_pkg::DIV_Q_W-1]};
  assign diff = sh - (REM_W+1)'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      rem  <= REM_W'(num[cpno_pkg::DIV_NUM_W-1:cpno_pkg::DIV_Q_W]);
      lo   <= num[cpno_pkg::DIV_Q_W-1:0];
      quo  <= '0;
      cnt  <= CNT_W'(cpno_pkg::DIV_Q_W);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        if (sh >= (REM_W+1)'(den)) begin
          rem <= diff[REM_W-1:0];
          quo <= {quo[cpno_pkg::DIV_Q_W-2:0], 1'b1};
        end else begin
          rem <= sh[REM_W-1:0];
          quo <= {quo[cpno_pkg::DIV_Q_W-2:0], 1'b0};
        end
        lo  <= lo << 1;
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== design/cpno_bscale.sv =====
// Block scaler: shifts the three components of a vector together, one bit
// per cycle, until the largest magnitude lies in [2^14, 2^15); for an
// all-zero vector it stops with the zero flag set. Depends on cpno_pkg.

module cpno_bscale (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [cpno_pkg::WIDE_W-1:0]  vin [3],
  output cpno_pkg::bs_stat_t                  stat,
  output logic signed [cpno_pkg::SCL_W-1:0]   vout [3]
);

  localparam int HI = cpno_pkg::SCL_W - 1;

  logic [cpno_pkg::WIDE_W-1:0] mag [3];
  logic [2:0]                  neg;
  logic                        busy;
  logic                        zero;
  logic                        any_hi;
  logic                        all_lo;
  logic                        all_zero;

  always_comb begin
    any_hi   = 1'b0;
    all_lo   = 1'b1;
    all_zero = 1'b1;
    for (int n = 0; n < 3; n++) begin
      if (mag[n][cpno_pkg::WIDE_W-1:HI] != '0) begin
        any_hi = 1'b1;
      end
      if (mag[n][cpno_pkg::WIDE_W-1:HI-1] != '0) begin
        all_lo = 1'b0;
      end
      if (mag[n] != '0) begin
        all_zero = 1'b0;
      end
    end
  end

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      vout[n] = neg[n] ? -$signed({1'b0, mag[n][HI-1:0]})
                       : $signed({1'b0, mag[n][HI-1:0]});
    end
  end

  assign stat.busy = busy;
  assign stat.zero = zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      zero <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      zero <= 1'b0;
      for (int n = 0; n < 3; n++) begin
        neg[n] <= vin[n][cpno_pkg::WIDE_W-1];
        mag[n] <= vin[n][cpno_pkg::WIDE_W-1] ? cpno_pkg::WIDE_W'(-vin[n])
                                             : cpno_pkg::WIDE_W'(vin[n]);
      end
    end else if (busy) begin
      if (all_zero) begin
        busy <= 1'b0;
        zero <= 1'b1;
      end else if (any_hi) begin
        // Right shifts truncate each magnitude toward zero.
        for (int n = 0; n < 3; n++) begin
          mag[n] <= mag[n] >> 1;
        end
      end else if (all_lo) begin
        for (int n = 0; n < 3; n++) begin
          mag[n] <= mag[n] << 1;
        end
      end else begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== design/control_polygon_normal_offset.sv =====
// Control polygon normal offset: top level with the sequencer and datapath.
// Depends on cpno_pkg, cpno_mul, cpno_sqrt, cpno_div and cpno_bscale.
//
// Usage: control points enter on the point channel (valid/ready), one
// transaction per point; last_point marks the end of a curve. Results leave on
// the result channel (valid/ready) through an output register. The signed
// offset is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. The
// first two points of a curve are only stored and are accepted at once,
// unless one of them is a last point. From the third point on, a point keeps
// the sequencer busy, and the next is accepted only once it is back in idle.
// Most of the work goes to the shift-and-add multiplier: 18 cross product
// terms, up to 9 squares and up to 9 offset products per point. Up to three
// 31-step square roots and up to nine 32-step divisions follow, and the block
// scaler shifts one bit per cycle. The third point gives two results, later
// points one, and a last point one more; a curve of fewer than three points
// gives one error result. If the receiver stalls, the result is held and the
// sequencer waits with the next result until the output register is free.
// Synchronous reset empties the point window, clears the offset to zero and
// drops result_valid.

module control_polygon_normal_offset (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                point_valid,
  output logic                                point_ready,
  input  cpno_pkg::point_t                    point,
  output logic                                result_valid,
  input  logic                                result_ready,
  output cpno_pkg::result_t                   result,
  input  logic                                cfg_we,
  input  logic signed [cpno_pkg::COORD_W-1:0] cfg_wdata
);

  localparam int CW = cpno_pkg::COORD_W;
  localparam int SW = cpno_pkg::SCL_W;
  localparam int WW = cpno_pkg::WIDE_W;

  // Saturation bounds of a 32-bit coordinate at the widened sum width.
  localparam logic signed [CW+2:0] SAT_HI = {4'b0000, {(CW-1){1'b1}}};
  localparam logic signed [CW+2:0] SAT_LO = {4'b1111, {(CW-1){1'b0}}};

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_DIFF   = 5'd1;
  localparam logic [4:0] ST_BSA    = 5'd2;
  localparam logic [4:0] ST_BSB    = 5'd3;
  localparam logic [4:0] ST_XMUL   = 5'd4;
  localparam logic [4:0] ST_XWAIT  = 5'd5;
  localparam logic [4:0] ST_XBSGO  = 5'd6;
  localparam logic [4:0] ST_XBS    = 5'd7;
  localparam logic [4:0] ST_SQMUL  = 5'd8;
  localparam logic [4:0] ST_SQWAIT = 5'd9;
  localparam logic [4:0] ST_SQGO   = 5'd10;
  localparam logic [4:0] ST_SQRT   = 5'd11;
  localparam logic [4:0] ST_DIV    = 5'd12;
  localparam logic [4:0] ST_DIVW   = 5'd13;
  localparam logic [4:0] ST_NEXT   = 5'd14;
  localparam logic [4:0] ST_EMSEL  = 5'd15;
  localparam logic [4:0] ST_EMUL   = 5'd16;
  localparam logic [4:0] ST_EMWAIT = 5'd17;
  localparam logic [4:0] ST_PUSH   = 5'd18;

  // Which vector pass is running.
  localparam logic [1:0] CS_N   = 2'd0;
  localparam logic [1:0] CS_C0  = 2'd1;
  localparam logic [1:0] CS_C1  = 2'd2;
  localparam logic [1:0] CS_SUM = 2'd3;

  // Which result is being formed.
  localparam logic [1:0] EM_FIRST = 2'd0;
  localparam logic [1:0] EM_INNER = 2'd1;
  localparam logic [1:0] EM_LAST  = 2'd2;

  logic [4:0]           state;
  logic [1:0]           points_seen;
  logic signed [CW-1:0] offset;
  logic signed [CW-1:0] older [3];
  logic signed [CW-1:0] prev [3];
  logic signed [CW-1:0] cur [3];
  logic                 last_in;
  logic                 err;

  logic signed [SW-1:0] asv [3];
  logic signed [SW-1:0] bsv [3];
  logic signed [SW-1:0] nsv [3];
  logic signed [SW-1:0] wv [3];
  logic signed [CW-1:0] cr [3];
  logic [CW-1:0]        m2;
  logic [cpno_pkg::ROOT_W-1:0] s;
  logic signed [CW-1:0] u0 [3];
  logic signed [CW-1:0] u1 [3];
  logic signed [CW-1:0] um [3];
  logic                 ok0;
  logic                 ok1;
  logic                 okm;

  logic [1:0]           csel;
  logic [2:0]           j;
  logic [1:0]           i;
  logic [1:0]           e;

  logic signed [CW-1:0] resv [3];
  logic                 res_deg;
  logic                 res_few;
  logic                 res_last;

  // Unit connections
  logic                 bs_start;
  logic signed [WW-1:0] bs_in [3];
  cpno_pkg::bs_stat_t   bs_st;
  logic signed [SW-1:0] bs_out [3];
  logic                 mul_start;
  logic signed [CW-1:0] mul_a;
  logic signed [CW-1:0] mul_b;
  logic                 mul_busy;
  logic [cpno_pkg::PROD_W-1:0] prod_mag;
  logic                 prod_neg;
  logic                 sq_start;
  logic                 sq_busy;
  logic [cpno_pkg::ROOT_W-1:0] sq_root;
  logic                 div_start;
  logic [cpno_pkg::DIV_NUM_W-1:0] div_num;
  logic                 div_busy;
  logic [cpno_pkg::DIV_Q_W-1:0] div_q;

  logic [1:0]           k;
  logic [1:0]           ix;
  logic [1:0]           iy;
  logic signed [SW-1:0] xop;
  logic signed [SW-1:0] yop;
  logic signed [CW-1:0] term;
  logic [SW-1:0]        w_mag;
  logic signed [CW-1:0] u_new;
  logic signed [CW-1:0] ep [3];
  logic signed [CW-1:0] eu [3];
  logic                 eok;
  logic [1:0]           e_end;
  logic [cpno_pkg::PROD_W-1:0] rnd_sum;
  logic [CW+1:0]        rnd;
  logic signed [CW+2:0] moved;
  logic signed [CW-1:0] moved_sat;
  logic                 out_free;
  logic                 accept;

  assign accept      = point_valid && point_ready;
  assign point_ready = (state == ST_IDLE);
  assign out_free    = !result_valid || result_ready;
  assign e_end       = last_in ? EM_LAST : EM_INNER;

  // Cross product operand order: even steps take x[k+1]*y[k+2], odd steps
  // the swapped pair, so component k is the even term minus the odd one.
  assign k = j[2:1];
  always_comb begin
    case (k)
      2'd0:    begin ix = j[0] ? 2'd2 : 2'd1; iy = j[0] ? 2'd1 : 2'd2; end
      2'd1:    begin ix = j[0] ? 2'd0 : 2'd2; iy = j[0] ? 2'd2 : 2'd0; end
      default: begin ix = j[0] ? 2'd1 : 2'd0; iy = j[0] ? 2'd0 : 2'd1; end
    endcase
    xop = (csel == CS_C1) ? bsv[ix] : asv[ix];
    yop = (csel == CS_N)  ? bsv[iy] : nsv[iy];
  end

  assign term = prod_neg ? -$signed(prod_mag[CW-1:0]) : $signed(prod_mag[CW-1:0]);

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      case (e)
        EM_FIRST: begin ep[n] = older[n]; eu[n] = u0[n]; end
        EM_INNER: begin ep[n] = prev[n];  eu[n] = um[n]; end
        default:  begin ep[n] = cur[n];   eu[n] = u1[n]; end
      endcase
    end
    case (e)
      EM_FIRST: eok = ok0;
      EM_INNER: eok = okm;
      default:  eok = ok1;
    endcase
  end

  // Block scaler input selection.
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      if (state == ST_DIFF) begin
        bs_in[n] = WW'(prev[n]) - WW'(older[n]);
      end else if (state == ST_BSA) begin
        bs_in[n] = WW'(cur[n]) - WW'(prev[n]);
      end else if (csel == CS_SUM) begin
        bs_in[n] = WW'(u0[n]) + WW'(u1[n]);
      end else begin
        bs_in[n] = WW'(cr[n]);
      end
    end
  end

  assign bs_start = (state == ST_DIFF) || (state == ST_XBSGO) ||
                    (state == ST_BSA && !bs_st.busy);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = offset;
    mul_b     = eu[i];
    case (state)
      ST_XMUL: begin
        mul_start = 1'b1;
        mul_a     = CW'(xop);
        mul_b     = CW'(yop);
      end
      ST_SQMUL: begin
        mul_start = 1'b1;
        mul_a     = CW'(wv[i]);
        mul_b     = CW'(wv[i]);
      end
      ST_EMUL: begin
        mul_start = 1'b1;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  assign sq_start  = (state == ST_SQGO);
  assign div_start = (state == ST_DIV);

  // Unit vector component: (|w| * 2^45 + s/2) / s, rounded half away from zero.
  assign w_mag   = wv[i][SW-1] ? SW'(-wv[i]) : SW'(wv[i]);
  assign div_num = {w_mag, 45'd0} + cpno_pkg::DIV_NUM_W'(s[cpno_pkg::ROOT_W-1:1]);
  assign u_new   = wv[i][SW-1] ? -$signed(div_q) : $signed(div_q);

  // Displacement rounded half away from zero, then added and saturated.
  assign rnd_sum = prod_mag + (cpno_pkg::PROD_W'(1) << (cpno_pkg::UNIT_FRAC - 1));
  assign rnd     = rnd_sum[cpno_pkg::PROD_W-1:cpno_pkg::UNIT_FRAC];
  assign moved   = (CW+3)'(ep[i]) +
                   (prod_neg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd}));
  always_comb begin
    if (moved > SAT_HI) begin
      moved_sat = {1'b0, {(CW-1){1'b1}}};
    end else if (moved < SAT_LO) begin
      moved_sat = {1'b1, {(CW-1){1'b0}}};
    end else begin
      moved_sat = moved[CW-1:0];
    end
  end

  cpno_bscale u_bscale (
    .clk   (clk),
    .rst   (rst),
    .start (bs_start),
    .vin   (bs_in),
    .stat  (bs_st),
    .vout  (bs_out)
  );

  cpno_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_start),
    .a        (mul_a),
    .b        (mul_b),
    .busy     (mul_busy),
    .prod_mag (prod_mag),
    .prod_neg (prod_neg)
  );

  cpno_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   ({m2, 30'd0}),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  cpno_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (s),
    .busy  (div_busy),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (cfg_we) begin
      offset <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_PUSH && out_free) begin
      result_valid          <= 1'b1;
      result.moved_x        <= resv[0];
      result.moved_y        <= resv[1];
      result.moved_z        <= resv[2];
      result.degenerate     <= res_deg;
      result.too_few_points <= res_few;
      result.last_result    <= res_last;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      points_seen <= 2'd0;
      for (int n = 0; n < 3; n++) begin
        older[n] <= '0;
        prev[n]  <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cur[0]  <= point.point_x;
            cur[1]  <= point.point_y;
            cur[2]  <= point.point_z;
            last_in <= point.last_point;
            if (points_seen < 2'd2) begin
              if (point.last_point) begin
                err      <= 1'b1;
                res_deg  <= 1'b0;
                res_few  <= 1'b1;
                res_last <= 1'b1;
                for (int n = 0; n < 3; n++) begin
                  resv[n] <= '0;
                end
                state <= ST_PUSH;
              end else begin
                if (points_seen == 2'd1) begin
                  for (int n = 0; n < 3; n++) begin
                    older[n] <= prev[n];
                  end
                end
                prev[0]     <= point.point_x;
                prev[1]     <= point.point_y;
                prev[2]     <= point.point_z;
                points_seen <= points_seen + 2'd1;
              end
            end else begin
              err   <= 1'b0;
              e     <= (points_seen == 2'd2) ? EM_FIRST : EM_INNER;
              state <= ST_DIFF;
            end
          end
        end
        ST_DIFF: begin
          state <= ST_BSA;
        end
        ST_BSA: begin
          if (!bs_st.busy) begin
            asv   <= bs_out;
            state <= ST_BSB;
          end
        end
        ST_BSB: begin
          if (!bs_st.busy) begin
            bsv   <= bs_out;
            csel  <= CS_N;
            j     <= 3'd0;
            state <= ST_XMUL;
          end
        end
        ST_XMUL: begin
          state <= ST_XWAIT;
        end
        ST_XWAIT: begin
          if (!mul_busy) begin
            cr[k] <= j[0] ? cr[k] - term : term;
            if (j == 3'd5) begin
              state <= ST_XBSGO;
            end else begin
              j     <= j + 3'd1;
              state <= ST_XMUL;
            end
          end
        end
        ST_XBSGO: begin
          state <= ST_XBS;
        end
        ST_XBS: begin
          if (!bs_st.busy) begin
            if (csel == CS_N) begin
              nsv   <= bs_out;
              csel  <= CS_C0;
              j     <= 3'd0;
              state <= ST_XMUL;
            end else begin
              wv <= bs_out;
              if (bs_st.zero) begin
                for (int n = 0; n < 3; n++) begin
                  case (csel)
                    CS_C0:   u0[n] <= '0;
                    CS_C1:   u1[n] <= '0;
                    default: um[n] <= '0;
                  endcase
                end
                case (csel)
                  CS_C0:   ok0 <= 1'b0;
                  CS_C1:   ok1 <= 1'b0;
                  default: okm <= 1'b0;
                endcase
                state <= ST_NEXT;
              end else begin
                m2    <= '0;
                i     <= 2'd0;
                state <= ST_SQMUL;
              end
            end
          end
        end
        ST_SQMUL: begin
          state <= ST_SQWAIT;
        end
        ST_SQWAIT: begin
          if (!mul_busy) begin
            m2 <= m2 + prod_mag[CW-1:0];
            if (i == 2'd2) begin
              state <= ST_SQGO;
            end else begin
              i     <= i + 2'd1;
              state <= ST_SQMUL;
            end
          end
        end
        ST_SQGO: begin
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (!sq_busy) begin
            s     <= sq_root;
            i     <= 2'd0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          state <= ST_DIVW;
        end
        ST_DIVW: begin
          if (!div_busy) begin
            case (csel)
              CS_C0:   u0[i] <= u_new;
              CS_C1:   u1[i] <= u_new;
              default: um[i] <= u_new;
            endcase
            if (i == 2'd2) begin
              case (csel)
                CS_C0:   ok0 <= 1'b1;
                CS_C1:   ok1 <= 1'b1;
                default: okm <= 1'b1;
              endcase
              state <= ST_NEXT;
            end else begin
              i     <= i + 2'd1;
              state <= ST_DIV;
            end
          end
        end
        ST_NEXT: begin
          case (csel)
            CS_C0: begin
              csel  <= CS_C1;
              j     <= 3'd0;
              state <= ST_XMUL;
            end
            CS_C1: begin
              csel  <= CS_SUM;
              state <= ST_XBSGO;
            end
            default: begin
              // The mean normal is only valid when both edge normals are.
              okm   <= okm && ok0 && ok1;
              state <= ST_EMSEL;
            end
          endcase
        end
        ST_EMSEL: begin
          res_few  <= 1'b0;
          res_last <= (e == EM_LAST);
          if (eok) begin
            res_deg <= 1'b0;
            i       <= 2'd0;
            state   <= ST_EMUL;
          end else begin
            res_deg <= 1'b1;
            resv    <= ep;
            state   <= ST_PUSH;
          end
        end
        ST_EMUL: begin
          state <= ST_EMWAIT;
        end
        ST_EMWAIT: begin
          if (!mul_busy) begin
            resv[i] <= moved_sat;
            if (i == 2'd2) begin
              state <= ST_PUSH;
            end else begin
              i     <= i + 2'd1;
              state <= ST_EMUL;
            end
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            if (err || e == e_end) begin
              if (err || last_in) begin
                points_seen <= 2'd0;
              end else begin
                older       <= prev;
                prev        <= cur;
                points_seen <= 2'd3;
              end
              state <= ST_IDLE;
            end else begin
              e     <= e + 2'd1;
              state <= ST_EMSEL;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/cpno_check.sv =====
// Port-level checks for the control polygon normal offset block, bound to
// its top level. Depends on cpno_pkg and control_polygon_normal_offset.

module cpno_check (
  input logic                                clk,
  input logic                                rst,
  input logic                                point_valid,
  input logic                                point_ready,
  input cpno_pkg::point_t                    point,
  input logic                                result_valid,
  input logic                                result_ready,
  input cpno_pkg::result_t                   result
);

  // A stalled point transaction holds its value.
  a_point_hold: assert property (@(posedge clk) disable iff (rst)
    point_valid && !point_ready |=> point_valid && $stable(point))
    else $error("point changed while waiting");

  // A stalled result transaction holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // The error result carries no point and closes the curve.
  a_few_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.too_few_points |->
      result.last_result && !result.degenerate && result.moved_x == 0 &&
      result.moved_y == 0 && result.moved_z == 0)
    else $error("malformed too_few_points result");

  a_deg_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |-> !result.too_few_points)
    else $error("degenerate and too_few_points both set");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result_valid high after reset");

endmodule

bind control_polygon_normal_offset cpno_check u_cpno_check (
  .clk          (clk),
  .rst          (rst),
  .point_valid  (point_valid),
  .point_ready  (point_ready),
  .point        (point),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
